[rtl/core/gnso_pkg.sv]
// ----------------------------------------------------------------------------
// gnso_pkg
// Shared types, register codes and helpers for the gather slice offset block.
// ----------------------------------------------------------------------------
package gnso_pkg;

    localparam int FIELD_DIMS         = 4;
    localparam int DEF_MAX_INDEX_DIMS = 4;
    localparam int DATA_W             = 32;
    localparam int DIM_W              = 16;
    localparam int DIMS_W             = 3;
    localparam int ADDR_W             = 5;
    localparam int REG_IDX_W          = 3;

    localparam logic [REG_IDX_W-1:0] REG_INDEX_DIMS       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIM_LEN_0        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIM_LEN_1        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIM_LEN_2        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIM_LEN_3        = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SLICE_ELEMS      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SLICES_PER_BATCH = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BATCH_STRIDE     = 3'd7;

    typedef struct packed {
        logic [DIMS_W-1:0]                  index_dims;
        logic [FIELD_DIMS-1:0][DIM_W-1:0]   dim_len;
        logic [DATA_W-1:0]                  slice_elems;
        logic [DATA_W-1:0]                  slices_per_batch;
        logic [DATA_W-1:0]                  batch_stride;
    } cfg_t;

    // tuple length clamped to 1..limit
    function automatic logic [DIMS_W-1:0] active_dims(
        input logic [DIMS_W-1:0] req,
        input logic [DIMS_W-1:0] limit
    );
        logic [DIMS_W-1:0] n;
        n = req;
        if (req == '0)
            n = DIMS_W'(1);
        else if (req > limit)
            n = limit;
        return n;
    endfunction

endpackage

[rtl/core/gnso_stride.sv]
// ----------------------------------------------------------------------------
// gnso_stride
// Stride sequencer: after any register write, walks the active
// dimensions from last to first, one 32x16 multiply per cycle.
// ----------------------------------------------------------------------------
module gnso_stride
    import gnso_pkg::*;
#(
    parameter int NUM_LANES = DEF_MAX_INDEX_DIMS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cfg_t                              cfg,
    input  logic                              cfg_wr,
    output logic                              ready,
    output logic [NUM_LANES-1:0][DATA_W-1:0]  strides
);

    localparam int KW = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [NUM_LANES-1:0][DATA_W-1:0]  strides_reg, strides_next;
    logic [DATA_W-1:0]                 running_reg, running_next;
    logic [KW-1:0]                     k_reg, k_next;
    logic [DIMS_W-1:0]                 n;
    logic [DATA_W+DIM_W-1:0]           prod;

    assign n    = active_dims(cfg.index_dims, DIMS_W'(NUM_LANES));
    assign prod = running_reg * cfg.dim_len[k_reg];

    always_comb
    begin
        state_next   = state_reg;
        strides_next = strides_reg;
        running_next = running_reg;
        k_next       = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_INIT:
            begin
                running_next = cfg.slice_elems;
                k_next       = KW'(n - DIMS_W'(1));
                strides_next = '0;
                state_next   = ST_RUN;
            end
            ST_RUN:
            begin
                strides_next[k_reg] = running_reg;
                running_next        = prod[DATA_W-1:0];
                if (k_reg == '0)
                    state_next = ST_IDLE;
                else
                    k_next = k_reg - KW'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_wr)
            state_next = ST_INIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            // reset config: one dim, one element per slice
            for (int i = 0; i < NUM_LANES; i++)
                strides_reg[i] <= (i == 0) ? DATA_W'(1) : '0;
        end
        else
        begin
            state_reg   <= state_next;
            strides_reg <= strides_next;
        end
    end

    always_ff @(posedge clk)
    begin
        running_reg <= running_next;
        k_reg       <= k_next;
    end

    assign ready   = (state_reg == ST_IDLE);
    assign strides = strides_reg;

    a_wr_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> !ready)
        else $error("stride table not marked busy after register write");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && k_reg == '0 && !cfg_wr) |=> ready)
        else $error("stride walk did not finish at first dimension");

    a_init_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT && !cfg_wr) |=> (k_reg == KW'(n - DIMS_W'(1))))
        else $error("stride walk started at wrong dimension");

endmodule

[rtl/core/gnso_lane.sv]
// ----------------------------------------------------------------------------
// gnso_lane
// One coordinate lane: wraps a negative coordinate by the dimension length
// and multiplies by the stride, low 32 bits registered.
// ----------------------------------------------------------------------------
module gnso_lane
    import gnso_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [DATA_W-1:0]  coord,
    input  logic [DIM_W-1:0]          dim_len,
    input  logic [DATA_W-1:0]         stride,
    output logic [DATA_W-1:0]         prod
);

    logic [DATA_W-1:0]    wrapped;
    logic [DATA_W-1:0]    full;
    logic [DATA_W-1:0]    prod_reg;

    assign wrapped = coord[DATA_W-1] ? ($unsigned(coord) + DATA_W'(dim_len))
                                     : $unsigned(coord);
    // only the low word of the product is kept
    assign full    = wrapped * stride;

    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= full;
    end

    assign prod = prod_reg;

endmodule

[rtl/core/gnso_merge.sv]
// ----------------------------------------------------------------------------
// gnso_merge
// Sums the lane products with the batch base into the output register.
// ----------------------------------------------------------------------------
module gnso_merge
    import gnso_pkg::*;
#(
    parameter int NUM_LANES = DEF_MAX_INDEX_DIMS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [NUM_LANES-1:0][DATA_W-1:0]  prods,
    input  logic [DATA_W-1:0]                 base,
    output logic                              load,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [DATA_W-1:0]                 flat_offset
);

    logic              valid_reg;
    logic [DATA_W-1:0] offset_reg;
    logic [DATA_W-1:0] sum;

    always_comb
    begin
        sum = base;
        for (int i = 0; i < NUM_LANES; i++)
            sum = sum + prods[i];
    end

    assign load = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            offset_reg <= sum;
    end

    assign out_valid   = valid_reg;
    assign flat_offset = offset_reg;

endmodule

[rtl/core/gather_nd_slice_offset.sv]
// ----------------------------------------------------------------------------
// gather_nd_slice_offset
// Flat slice offset generator for an N-dimensional gather, one lane per
// coordinate, a per-batch tuple counter advancing the batch base.
// ----------------------------------------------------------------------------
// An accepted word is registered by the lane multiply, then by the merge stage.
// Throughput: one word per cycle unless out_ready or a stride rebuild stalls;
// the lane multipliers are fully pipelined. A register write rebuilds the
// stride table, one 32x16 multiply per dimension; in_ready is low meanwhile.
// Reset: registers take their reset values, strides are preset, the batch
// counter and base clear; no clearing pass.
// ----------------------------------------------------------------------------
module gather_nd_slice_offset
    import gnso_pkg::*;
#(
    parameter int MAX_INDEX_DIMS = DEF_MAX_INDEX_DIMS
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [DATA_W-1:0]  coord_0,
    input  logic signed [DATA_W-1:0]  coord_1,
    input  logic signed [DATA_W-1:0]  coord_2,
    input  logic signed [DATA_W-1:0]  coord_3,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [DATA_W-1:0]         flat_offset
);

    localparam int NUM_LANES = (MAX_INDEX_DIMS < FIELD_DIMS) ? MAX_INDEX_DIMS : FIELD_DIMS;

    cfg_t                              cfg_reg;
    logic                              cfg_wr;
    logic [REG_IDX_W-1:0]              reg_idx;
    logic                              stride_ready;
    logic [NUM_LANES-1:0][DATA_W-1:0]  strides;
    logic [NUM_LANES-1:0][DATA_W-1:0]  prods;
    logic [FIELD_DIMS-1:0][DATA_W-1:0] coord_vec;

    logic                              accept;
    logic                              s2_load;
    logic                              s1_valid_reg;
    logic [DATA_W-1:0]                 base_s1_reg;

    logic [DATA_W-1:0]                 tuples_reg, tuples_next;
    logic [DATA_W-1:0]                 batch_base_reg, batch_base_next;
    logic [DATA_W-1:0]                 limit;
    logic [DATA_W:0]                   tuples_inc;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.index_dims       <= DIMS_W'(1);
            cfg_reg.dim_len          <= {FIELD_DIMS{DIM_W'(1)}};
            cfg_reg.slice_elems      <= DATA_W'(1);
            cfg_reg.slices_per_batch <= DATA_W'(1);
            cfg_reg.batch_stride     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_INDEX_DIMS:       cfg_reg.index_dims       <= pwdata[DIMS_W-1:0];
                REG_DIM_LEN_0:        cfg_reg.dim_len[0]       <= pwdata[DIM_W-1:0];
                REG_DIM_LEN_1:        cfg_reg.dim_len[1]       <= pwdata[DIM_W-1:0];
                REG_DIM_LEN_2:        cfg_reg.dim_len[2]       <= pwdata[DIM_W-1:0];
                REG_DIM_LEN_3:        cfg_reg.dim_len[3]       <= pwdata[DIM_W-1:0];
                REG_SLICE_ELEMS:      cfg_reg.slice_elems      <= pwdata;
                REG_SLICES_PER_BATCH: cfg_reg.slices_per_batch <= pwdata;
                REG_BATCH_STRIDE:     cfg_reg.batch_stride     <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_INDEX_DIMS:       prdata = DATA_W'(cfg_reg.index_dims);
            REG_DIM_LEN_0:        prdata = DATA_W'(cfg_reg.dim_len[0]);
            REG_DIM_LEN_1:        prdata = DATA_W'(cfg_reg.dim_len[1]);
            REG_DIM_LEN_2:        prdata = DATA_W'(cfg_reg.dim_len[2]);
            REG_DIM_LEN_3:        prdata = DATA_W'(cfg_reg.dim_len[3]);
            REG_SLICE_ELEMS:      prdata = cfg_reg.slice_elems;
            REG_SLICES_PER_BATCH: prdata = cfg_reg.slices_per_batch;
            REG_BATCH_STRIDE:     prdata = cfg_reg.batch_stride;
            default:              prdata = '0;
        endcase
    end

    // ---------------- stride table ----------------
    gnso_stride #(
        .NUM_LANES (NUM_LANES)
    ) u_stride (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .cfg_wr  (cfg_wr),
        .ready   (stride_ready),
        .strides (strides)
    );

    // ---------------- lanes ----------------
    assign in_ready = stride_ready && (!s1_valid_reg || s2_load);
    assign accept   = in_valid && in_ready;

    assign coord_vec = {coord_3, coord_2, coord_1, coord_0};

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        gnso_lane u_lane (
            .clk     (clk),
            .en      (accept),
            .coord   (coord_vec[g]),
            .dim_len (cfg_reg.dim_len[g]),
            .stride  (strides[g]),
            .prod    (prods[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!s1_valid_reg || s2_load)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            base_s1_reg <= batch_base_reg;
    end

    // ---------------- batch counter ----------------
    // all-ones count wraps too: the 33-bit increment always reaches limit
    assign limit      = (cfg_reg.slices_per_batch == '0) ? DATA_W'(1)
                                                         : cfg_reg.slices_per_batch;
    assign tuples_inc = {1'b0, tuples_reg} + (DATA_W+1)'(1);

    always_comb
    begin
        tuples_next     = tuples_reg;
        batch_base_next = batch_base_reg;
        if (accept)
        begin
            if (tuples_inc >= {1'b0, limit})
            begin
                tuples_next     = '0;
                batch_base_next = batch_base_reg + cfg_reg.batch_stride;
            end
            else
            begin
                tuples_next = tuples_inc[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuples_reg     <= '0;
            batch_base_reg <= '0;
        end
        else
        begin
            tuples_reg     <= tuples_next;
            batch_base_reg <= batch_base_next;
        end
    end

    // ---------------- merge ----------------
    gnso_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s1_valid_reg),
        .prods       (prods),
        .base        (base_s1_reg),
        .load        (s2_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .flat_offset (flat_offset)
    );

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word missing from lane stage");

    a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_load) |=> out_valid)
        else $error("lane stage word not moved to output");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> (s1_valid_reg && $stable(base_s1_reg)))
        else $error("stalled lane stage word lost or changed");

endmodule
